### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define AST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define AST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ast_pkg.sv
package ast_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CNT_W           = 10;
  localparam int SETTLE_W        = 8;
  localparam int DELTA_W         = 16;
  localparam int MASK_W          = 3;
  localparam int PHASE_W         = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int NUM_AXES        = 3;
  localparam int AXIS_W          = 2;

  localparam logic [SETTLE_W-1:0] SETTLE_RST = 8'd10;
  localparam logic [CNT_W-1:0]    AVG_RST    = 10'd320;
  localparam logic [DELTA_W-1:0]  MIN_X_RST  = 16'd93;
  localparam logic [DELTA_W-1:0]  MIN_Y_RST  = 16'hFFA3;
  localparam logic [DELTA_W-1:0]  MIN_Z_RST  = 16'd112;
  localparam logic [MASK_W-1:0]   MASK_RST   = 3'b111;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE       = 3'd0,
    PH_SETTLE_OFF = 3'd1,
    PH_AVG_OFF    = 3'd2,
    PH_SETTLE_ON  = 3'd3,
    PH_AVG_ON     = 3'd4,
    PH_DONE       = 3'd5
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETTLE = 3'd0,
    CFG_AVG    = 3'd1,
    CFG_MIN_X  = 3'd2,
    CFG_MIN_Y  = 3'd3,
    CFG_MIN_Z  = 3'd4,
    CFG_MASK   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [SETTLE_W-1:0] settle_count;
    logic [CNT_W-1:0]    average_count;
    logic [DELTA_W-1:0]  min_delta_x;
    logic [DELTA_W-1:0]  min_delta_y;
    logic [DELTA_W-1:0]  min_delta_z;
    logic [MASK_W-1:0]   check_mask;
  } cfg_t;

  typedef struct packed {
    logic              capture;
    logic              clear;
    logic              div_load;
    logic              div_step;
    logic              mean_wb;
    logic              eval;
    logic              emit;
    logic              test_sel;
    logic [AXIS_W-1:0] axis;
    logic [CNT_W-1:0]  divisor;
    phase_e            phase;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

### hdl/ast_if.sv
interface ast_cfg_if;
  import ast_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface ast_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;
  modport source (output valid, output kind, output accel_x, output accel_y,
                  output accel_z, input ready);
  modport sink (input valid, input kind, input accel_x, input accel_y,
                input accel_z, output ready);
endinterface

interface ast_out_if;
  import ast_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [PHASE_W-1:0]         phase;
  logic                       self_test_request;
  logic                       done_res;
  logic                       pass;
  logic signed [DELTA_W-1:0]  change_x;
  logic signed [DELTA_W-1:0]  change_y;
  logic signed [DELTA_W-1:0]  change_z;
  modport source (output valid, output phase, output self_test_request, output done_res,
                  output pass, output change_x, output change_y, output change_z,
                  input ready);
  modport sink (input valid, input phase, input self_test_request, input done_res,
                input pass, input change_x, input change_y, input change_z,
                output ready);
endinterface

### hdl/accel_self_test_evaluator.sv
// Three-axis accelerometer self-test evaluator. A kind=0 transaction starts a sequence and
// clears all averages; kind=1 transactions carry samples, which are discarded for
// settle_count samples, averaged with self-test off for average_count samples, discarded
// again, then averaged with self_test_request high. Every input transaction yields exactly
// one result showing the phase after it; once both averages are done, done_res, pass and the
// per-axis change are reported. Start, settle and ignored samples go straight to the result.
// In an averaging phase, each axis of a sample goes in turn through one shared restoring
// divider that retires one quotient bit per cycle, and its new mean is written back; a
// sample that closes the sequence then passes an evaluate step before its result.
// A new transaction is taken while the previous result still waits in the output register.
// Configuration writes are taken at any time and must only be issued while idle.
module accel_self_test_evaluator
  import ast_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ast_cfg_if.sink       cfg_i,
  ast_in_if.sink        in_i,
  ast_out_if.source     out_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  ast_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_i.ready),
    .cfg_o       (cfg)
  );

  ast_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ast_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .accel_x_i           (in_i.accel_x),
    .accel_y_i           (in_i.accel_y),
    .accel_z_i           (in_i.accel_z),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_valid_o         (out_o.valid),
    .out_ready_i         (out_o.ready),
    .phase_o             (out_o.phase),
    .self_test_request_o (out_o.self_test_request),
    .done_res_o          (out_o.done_res),
    .pass_o              (out_o.pass),
    .change_x_o          (out_o.change_x),
    .change_y_o          (out_o.change_y),
    .change_z_o          (out_o.change_z)
  );

endmodule

### hdl/ast_cfg.sv
module ast_cfg
  import ast_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  cfg_ready_o,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SETTLE: cfg_d.settle_count  = cfg_data_i[SETTLE_W-1:0];
        CFG_AVG:    cfg_d.average_count = cfg_data_i[CNT_W-1:0];
        CFG_MIN_X:  cfg_d.min_delta_x   = cfg_data_i[DELTA_W-1:0];
        CFG_MIN_Y:  cfg_d.min_delta_y   = cfg_data_i[DELTA_W-1:0];
        CFG_MIN_Z:  cfg_d.min_delta_z   = cfg_data_i[DELTA_W-1:0];
        CFG_MASK:   cfg_d.check_mask    = cfg_data_i[MASK_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_count  <= SETTLE_RST;
      cfg_q.average_count <= AVG_RST;
      cfg_q.min_delta_x   <= MIN_X_RST;
      cfg_q.min_delta_y   <= MIN_Y_RST;
      cfg_q.min_delta_z   <= MIN_Z_RST;
      cfg_q.check_mask    <= MASK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### hdl/ast_dp.sv
module ast_dp
  import ast_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic signed [SAMPLE_BITS-1:0] accel_x_i,
  input  logic signed [SAMPLE_BITS-1:0] accel_y_i,
  input  logic signed [SAMPLE_BITS-1:0] accel_z_i,
  input  cmd_t                          cmd_i,
  output sts_t                          sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [PHASE_W-1:0]            phase_o,
  output logic                          self_test_request_o,
  output logic                          done_res_o,
  output logic                          pass_o,
  output logic signed [DELTA_W-1:0]     change_x_o,
  output logic signed [DELTA_W-1:0]     change_y_o,
  output logic signed [DELTA_W-1:0]     change_z_o
);

  localparam int BCW = $clog2(SAMPLE_BITS + 1);
  localparam int CW  = (SAMPLE_BITS > DELTA_W) ? SAMPLE_BITS : DELTA_W;

  logic [SAMPLE_BITS-1:0] smp_q    [NUM_AXES];
  logic [SAMPLE_BITS-1:0] normal_q [NUM_AXES];
  logic [SAMPLE_BITS-1:0] test_q   [NUM_AXES];

  logic [SAMPLE_BITS-1:0] dvd_q;
  logic [CNT_W-1:0]       rem_q;
  logic                   neg_q;
  logic [BCW-1:0]         bcnt_q;
  logic                   done_q;
  logic                   pass_q;

  logic [SAMPLE_BITS-1:0] cur_smp, cur_mean, diff, mag, quot, new_mean;
  logic [CNT_W:0]         rem_sh, rem_nx;
  logic                   ge;

  logic [SAMPLE_BITS-1:0] chg     [NUM_AXES];
  logic signed [CW-1:0]   chg_ext [NUM_AXES];
  logic signed [CW-1:0]   min_ext [NUM_AXES];
  logic [NUM_AXES-1:0]    fail;
  logic                   out_valid_q;

  always_comb begin
    cur_smp  = smp_q[cmd_i.axis];
    cur_mean = cmd_i.test_sel ? test_q[cmd_i.axis] : normal_q[cmd_i.axis];
    diff     = cur_smp - cur_mean;
    mag      = diff[SAMPLE_BITS-1] ? (~diff + SAMPLE_BITS'(1)) : diff;
    rem_sh   = {rem_q, dvd_q[SAMPLE_BITS-1]};
    ge       = rem_sh >= {1'b0, cmd_i.divisor};
    rem_nx   = ge ? (rem_sh - {1'b0, cmd_i.divisor}) : rem_sh;
    quot     = neg_q ? (~dvd_q + SAMPLE_BITS'(1)) : dvd_q;
    new_mean = cur_mean + quot;
  end

  always_comb begin
    min_ext[0] = CW'($signed(cfg_i.min_delta_x));
    min_ext[1] = CW'($signed(cfg_i.min_delta_y));
    min_ext[2] = CW'($signed(cfg_i.min_delta_z));
    for (int j = 0; j < NUM_AXES; j++) begin
      chg[j]     = test_q[j] - normal_q[j];
      chg_ext[j] = CW'($signed(chg[j]));
      fail[j]    = cfg_i.check_mask[j] && (chg_ext[j] < min_ext[j]);
    end
  end

  assign sts_o.div_done = (bcnt_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      smp_q[0] <= accel_x_i;
      smp_q[1] <= accel_y_i;
      smp_q[2] <= accel_z_i;
    end
    if (cmd_i.div_load) begin
      dvd_q <= mag;
      rem_q <= '0;
      neg_q <= diff[SAMPLE_BITS-1];
    end else if (cmd_i.div_step && (bcnt_q != '0)) begin
      dvd_q <= {dvd_q[SAMPLE_BITS-2:0], ge};
      rem_q <= rem_nx[CNT_W-1:0];
    end
    if (cmd_i.emit) begin
      phase_o             <= cmd_i.phase;
      self_test_request_o <= (cmd_i.phase == PH_SETTLE_ON) || (cmd_i.phase == PH_AVG_ON);
      done_res_o          <= done_q;
      pass_o              <= done_q && pass_q;
      change_x_o          <= done_q ? chg_ext[0][DELTA_W-1:0] : '0;
      change_y_o          <= done_q ? chg_ext[1][DELTA_W-1:0] : '0;
      change_z_o          <= done_q ? chg_ext[2][DELTA_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        normal_q[j] <= '0;
        test_q[j]   <= '0;
      end
      bcnt_q      <= '0;
      done_q      <= 1'b0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          normal_q[j] <= '0;
          test_q[j]   <= '0;
        end
        done_q <= 1'b0;
        pass_q <= 1'b0;
      end else if (cmd_i.mean_wb) begin
        if (cmd_i.test_sel) begin
          test_q[cmd_i.axis] <= new_mean;
        end else begin
          normal_q[cmd_i.axis] <= new_mean;
        end
      end else if (cmd_i.eval) begin
        done_q <= 1'b1;
        pass_q <= ~|fail;
      end
      if (cmd_i.div_load) begin
        bcnt_q <= BCW'(SAMPLE_BITS);
      end else if (cmd_i.div_step && (bcnt_q != '0)) begin
        bcnt_q <= bcnt_q - BCW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### hdl/ast_ctrl.sv
`include "assert_macros.svh"

module ast_ctrl
  import ast_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  input  logic in_kind_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_RUN  = 6'b000100,
    S_WB   = 6'b001000,
    S_EVAL = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [AXIS_W-1:0] axis_q, axis_d;
  logic [CNT_W-1:0]  cnt_inc, avg_eff;
  logic              settle_zero;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cnt_inc     = cnt_q + CNT_W'(1);
  assign avg_eff     = (cfg_i.average_count == '0) ? CNT_W'(1) : cfg_i.average_count;
  assign settle_zero = (cfg_i.settle_count == '0);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    axis_d  = axis_q;

    cmd_o          = '0;
    cmd_o.axis     = axis_q;
    cmd_o.divisor  = n_q;
    cmd_o.test_sel = (phase_q == PH_AVG_ON);
    cmd_o.phase    = phase_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EMIT;
          if (!in_kind_i) begin
            cmd_o.clear = 1'b1;
            cnt_d       = '0;
            phase_d     = settle_zero ? PH_AVG_OFF : PH_SETTLE_OFF;
          end else begin
            case (phase_q)
              PH_SETTLE_OFF, PH_SETTLE_ON: begin
                if (cnt_inc >= CNT_W'(cfg_i.settle_count)) begin
                  cnt_d   = '0;
                  phase_d = (phase_q == PH_SETTLE_OFF) ? PH_AVG_OFF : PH_AVG_ON;
                end else begin
                  cnt_d = cnt_inc;
                end
              end
              PH_AVG_OFF, PH_AVG_ON: begin
                n_d     = (cnt_inc == '0) ? CNT_W'(1) : cnt_inc;
                axis_d  = '0;
                state_d = S_LOAD;
              end
              default: state_d = S_EMIT;
            endcase
          end
        end
      end
      S_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = S_RUN;
      end
      S_RUN: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        cmd_o.mean_wb = 1'b1;
        if (axis_q == AXIS_W'(NUM_AXES - 1)) begin
          if (n_q >= avg_eff) begin
            cnt_d = '0;
            if (phase_q == PH_AVG_OFF) begin
              phase_d = settle_zero ? PH_AVG_ON : PH_SETTLE_ON;
              state_d = S_EMIT;
            end else begin
              state_d = S_EVAL;
            end
          end else begin
            cnt_d   = n_q;
            state_d = S_EMIT;
          end
        end else begin
          axis_d  = axis_q + AXIS_W'(1);
          state_d = S_LOAD;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        phase_d    = PH_DONE;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      axis_q  <= axis_d;
    end
  end

  `AST_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q != S_IDLE), "accepted transaction left controller idle")
  `AST_ASSERT(a_div_to_wb, clk_i, rst_ni, (state_q == S_RUN && sts_i.div_done) |=> (state_q == S_WB), "divider finish not followed by writeback")
  `AST_ASSERT(a_axis_range, clk_i, rst_ni, axis_q <= AXIS_W'(NUM_AXES - 1), "axis index out of range")
  `AST_ASSERT_ALWAYS(a_phase_range, clk_i, phase_q <= PH_DONE, "phase beyond finished")

endmodule
